[rtl/core/grdfs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grdfs_pkg
// Shared types, constants and helper functions for the graph reachability
// unit: sizes, opcodes, controller states and controller/datapath signals.
// ----------------------------------------------------------------------------
package grdfs_pkg;

    // graph size limit and derived widths
    localparam int MAX_VERTS = 64;
    localparam int VIDX_W    = $clog2(MAX_VERTS);
    localparam int ROW_W     = 64;
    localparam int CNT_W     = 7;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(64);

    // item opcodes
    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } opcode_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXPAND,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_row;
        logic start_good;
        logic start_bad;
        logic expand;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_search;
        logic start_bad;
        logic frontier_empty;
        logic out_free;
    } status_t;

    // mask with the low n bits set
    function automatic logic [ROW_W-1:0] low_mask(input logic [CNT_W-1:0] n);
        logic [ROW_W-1:0] m;
        m = '0;
        for (int i = 0; i < ROW_W; i++) begin
            m[i] = (CNT_W'(i) < n);
        end
        return m;
    endfunction

    // index of the lowest set bit, zero when none is set
    function automatic logic [VIDX_W-1:0] lowest_index(input logic [ROW_W-1:0] v);
        logic [VIDX_W-1:0] idx;
        idx = '0;
        for (int i = MAX_VERTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = VIDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

[rtl/core/grdfs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grdfs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module grdfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

[rtl/core/grdfs_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grdfs_ctrl
// Controller state machine: takes items while idle, runs the expansion
// loop of a search and hands the result to the output register.
// ----------------------------------------------------------------------------
module grdfs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire grdfs_pkg::status_t sts,
    output grdfs_pkg::cmd_t         cmd
);

    grdfs_pkg::state_t state_reg;
    grdfs_pkg::state_t state_next;
    logic              take;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grdfs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            grdfs_pkg::S_IDLE:
            begin
                if (in_valid && sts.is_search)
                begin
                    state_next = sts.start_bad ? grdfs_pkg::S_DONE : grdfs_pkg::S_EXPAND;
                end
            end
            grdfs_pkg::S_EXPAND:
            begin
                if (sts.frontier_empty)
                begin
                    state_next = grdfs_pkg::S_DONE;
                end
            end
            grdfs_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = grdfs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = grdfs_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        take           = in_valid && (state_reg == grdfs_pkg::S_IDLE);
        in_stall       = (state_reg != grdfs_pkg::S_IDLE);
        cmd.load_row   = take && !sts.is_search;
        cmd.start_good = take && sts.is_search && !sts.start_bad;
        cmd.start_bad  = take && sts.is_search && sts.start_bad;
        cmd.expand     = (state_reg == grdfs_pkg::S_EXPAND);
        cmd.emit       = (state_reg == grdfs_pkg::S_DONE) && sts.out_free;
    end

endmodule
`default_nettype wire

[rtl/core/grdfs_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grdfs_dpath
// Datapath: vertex count register, adjacency row memory, visited and
// frontier masks, lowest-vertex picker and the output register.
// ----------------------------------------------------------------------------
module grdfs_dpath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write_en,
    input  wire logic [grdfs_pkg::CNT_W-1:0]           cfg_write_data,
    input  wire logic                                  opcode,
    input  wire logic [5:0]                            row_index,
    input  wire logic [grdfs_pkg::ROW_W-1:0]           row_bits,
    input  wire logic [grdfs_pkg::CNT_W-1:0]           start_vertex,
    input  wire grdfs_pkg::cmd_t                       cmd,
    output grdfs_pkg::status_t                         sts,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic      [grdfs_pkg::ROW_W-1:0]           reached_mask,
    output logic                                       bad_start
);

    logic [grdfs_pkg::CNT_W-1:0]  vcount_reg;
    logic [grdfs_pkg::ROW_W-1:0]  visited_reg;
    logic [grdfs_pkg::ROW_W-1:0]  visited_next;
    logic [grdfs_pkg::ROW_W-1:0]  pending_reg;
    logic [grdfs_pkg::ROW_W-1:0]  pending_next;
    logic [grdfs_pkg::ROW_W-1:0]  limit_reg;
    logic                         bad_reg;
    logic                         out_valid_reg;
    logic [grdfs_pkg::ROW_W-1:0]  mask_out_reg;
    logic                         bad_out_reg;

    logic [grdfs_pkg::CNT_W-1:0]  n_eff;
    logic [grdfs_pkg::CNT_W-1:0]  start_m1;
    logic [grdfs_pkg::VIDX_W-1:0] start_idx;
    logic                         start_bad;
    logic                         row_ok;
    logic [grdfs_pkg::ROW_W-1:0]  rd_data;
    logic [grdfs_pkg::ROW_W-1:0]  fresh;
    logic [grdfs_pkg::ROW_W-1:0]  frontier;
    logic [grdfs_pkg::VIDX_W-1:0] pick_idx;
    logic [grdfs_pkg::VIDX_W-1:0] raddr;

    // vertex count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= grdfs_pkg::VCOUNT_RESET;
        end
        else if (cfg_write_en)
        begin
            vcount_reg <= cfg_write_data;
        end
    end

    // start check against the clamped vertex count
    always_comb
    begin
        n_eff     = (vcount_reg > grdfs_pkg::CNT_W'(grdfs_pkg::MAX_VERTS))
                    ? grdfs_pkg::CNT_W'(grdfs_pkg::MAX_VERTS) : vcount_reg;
        start_bad = (start_vertex == '0) || (start_vertex > n_eff);
        start_m1  = start_vertex - grdfs_pkg::CNT_W'(1);
        start_idx = start_m1[grdfs_pkg::VIDX_W-1:0];
        row_ok    = ({1'b0, row_index} < grdfs_pkg::CNT_W'(grdfs_pkg::MAX_VERTS));
    end

    // adjacency rows
    grdfs_ram #(
        .WIDTH (grdfs_pkg::ROW_W),
        .DEPTH (grdfs_pkg::MAX_VERTS)
    ) u_rows (
        .clk   (clk),
        .we    (cmd.load_row && row_ok),
        .waddr (row_index[grdfs_pkg::VIDX_W-1:0]),
        .wdata (row_bits & grdfs_pkg::low_mask(grdfs_pkg::CNT_W'(grdfs_pkg::MAX_VERTS))),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // expand the row just read and pick the next vertex to fetch
    always_comb
    begin
        fresh    = rd_data & limit_reg & ~visited_reg;
        frontier = pending_reg | fresh;
        pick_idx = grdfs_pkg::lowest_index(frontier);
        raddr    = cmd.start_good ? start_idx : pick_idx;
    end

    // visited and frontier update
    always_comb
    begin
        visited_next = visited_reg;
        pending_next = pending_reg;
        if (cmd.start_good)
        begin
            visited_next = grdfs_pkg::ROW_W'(1) << start_idx;
            pending_next = '0;
        end
        else if (cmd.start_bad)
        begin
            visited_next = '0;
            pending_next = '0;
        end
        else if (cmd.expand)
        begin
            visited_next = visited_reg | fresh;
            pending_next = frontier & ~(grdfs_pkg::ROW_W'(1) << pick_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
            pending_reg <= '0;
            bad_reg     <= 1'b0;
        end
        else
        begin
            visited_reg <= visited_next;
            pending_reg <= pending_next;
            if (cmd.start_good || cmd.start_bad)
            begin
                bad_reg <= cmd.start_bad;
            end
        end
    end

    // reach limit for the current search
    always_ff @(posedge clk)
    begin
        if (cmd.start_good)
        begin
            limit_reg <= grdfs_pkg::low_mask(n_eff);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            mask_out_reg <= visited_reg;
            bad_out_reg  <= bad_reg;
        end
    end

    // status to the controller and ports
    always_comb
    begin
        sts.is_search      = (opcode == grdfs_pkg::OP_SEARCH);
        sts.start_bad      = start_bad;
        sts.frontier_empty = (frontier == '0);
        sts.out_free       = !out_valid_reg || !out_stall;
        out_valid          = out_valid_reg;
        reached_mask       = mask_out_reg;
        bad_start          = bad_out_reg;
    end

    // every pending vertex is already marked visited
    a_pending_in_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg & ~visited_reg) == '0)
        else $error("pending vertex not in visited set");

    // a new search begins with only its start vertex visited
    a_start_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_good |=> $onehot(visited_reg) && (pending_reg == '0))
        else $error("search did not start from a single vertex");

    // a bad start never reports reached vertices
    a_bad_zero_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && bad_out_reg |-> mask_out_reg == '0)
        else $error("bad start with non-zero mask");

endmodule
`default_nettype wire

[rtl/core/graph_reachability_dfs_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// graph_reachability_dfs_unit
// Reachability search over an adjacency-matrix graph of up to 64 vertices:
// load items store adjacency rows, search items return the reachable mask.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid / in_stall  opcode, row_index, row_bits, start_vertex
//   out      out_valid/ out_stall reached_mask, bad_start
//   cfg      cfg_write_en         cfg_write_data (vertex_count)
//
// a load is written to its row when taken; a search reads the adjacency row
// of each reachable vertex (at most 64), one adjacency row read per cycle
// from the single read port of the row memory; a bad start skips the expansion
// reset sets vertex_count to 64 and empties the visited set; rows are
// undefined until loaded
// a stalled output holds its result while the next item is already taken
// ----------------------------------------------------------------------------
module graph_reachability_dfs_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [6:0]  cfg_write_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [5:0]  row_index,
    input  wire logic [63:0] row_bits,
    input  wire logic [6:0]  start_vertex,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [63:0] reached_mask,
    output logic             bad_start
);

    grdfs_pkg::cmd_t    cmd;
    grdfs_pkg::status_t sts;

    // controller
    grdfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    grdfs_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .opcode         (opcode),
        .row_index      (row_index),
        .row_bits       (row_bits),
        .start_vertex   (start_vertex),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .reached_mask   (reached_mask),
        .bad_start      (bad_start)
    );

endmodule
`default_nettype wire

[tb/sv/graph_reachability_dfs_checker.sv]
// ----------------------------------------------------------------------------
// graph_reachability_dfs_checker
// Watches the item, result and vertex count channels of the reachability
// unit. It keeps its own copy of the adjacency rows and of the vertex count,
// works out the reachable mask for every accepted search and compares each
// accepted result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module graph_reachability_dfs_checker
    import grdfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [6:0]  cfg_write_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        opcode,
    input  logic [5:0]  row_index,
    input  logic [63:0] row_bits,
    input  logic [6:0]  start_vertex,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] reached_mask,
    input  logic        bad_start,
    output int          fail_count,
    output int          pending_results
);

    typedef struct packed {
        logic [63:0] mask;
        logic        bad;
    } reach_result_t;

    logic [63:0]   adj_rows [MAX_VERTS];
    logic [6:0]    vertex_count;
    reach_result_t reach_q [$];

    initial begin
        fail_count      = 0;
        pending_results = 0;
        vertex_count    = VCOUNT_RESET;
        for (int k = 0; k < MAX_VERTS; k++) begin
            adj_rows[k] = '0;
        end
    end

    // closure of the start vertex over the rows, limited to the vertex count
    function automatic reach_result_t predict_reach(input logic [6:0] start);
        reach_result_t r;
        int            n;
        logic [63:0]   limit;
        logic [63:0]   reached;
        logic [63:0]   prev;
        n = (int'(vertex_count) > MAX_VERTS) ? MAX_VERTS : int'(vertex_count);
        r.mask = '0;
        r.bad  = 1'b1;
        if (start == 7'd0 || int'(start) > n) begin
            return r;
        end
        limit   = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        reached = 64'd1 << (start - 7'd1);
        do begin
            prev = reached;
            for (int v = 0; v < MAX_VERTS; v++) begin
                if (prev[v]) begin
                    reached = reached | (adj_rows[v] & limit);
                end
            end
        end while (reached != prev);
        r.mask = reached;
        r.bad  = 1'b0;
        return r;
    endfunction

    // track configuration, predict on accepted items, compare accepted results
    always @(posedge clk or negedge rst_n) begin
        reach_result_t want;
        if (!rst_n) begin
            vertex_count = VCOUNT_RESET;
            reach_q.delete();
            pending_results = 0;
        end
        else begin
            if (cfg_write_en) begin
                vertex_count = cfg_write_data;
            end
            if (in_valid && !in_stall) begin
                if (opcode_t'(opcode) == OP_SEARCH) begin
                    reach_q.push_back(predict_reach(start_vertex));
                end
                else begin
                    adj_rows[row_index] = row_bits;
                end
            end
            if (out_valid && !out_stall) begin
                if (reach_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result mask=%h bad_start=%b",
                             $time, reached_mask, bad_start);
                end
                else begin
                    want = reach_q.pop_front();
                    if (reached_mask !== want.mask) begin
                        fail_count++;
                        $display("%0t: reached_mask expected %h actual %h",
                                 $time, want.mask, reached_mask);
                    end
                    if (bad_start !== want.bad) begin
                        fail_count++;
                        $display("%0t: bad_start expected %b actual %b",
                                 $time, want.bad, bad_start);
                    end
                end
            end
            pending_results = reach_q.size();
        end
    end

endmodule

[tb/sv/tb_graph_reachability_dfs_unit.sv]
// ----------------------------------------------------------------------------
// tb_graph_reachability_dfs_unit
// Stimulus and verdict for the reachability unit: loads every adjacency row,
// runs directed searches over the vertex count extremes and bad starts, then
// random phases of loads and searches under several vertex counts, with
// random idle gaps, output stalls and one long output hold.
// ----------------------------------------------------------------------------
module tb_graph_reachability_dfs_unit;
    import grdfs_pkg::*;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [6:0]  cfg_write_data = '0;
    logic        in_valid       = 1'b0;
    logic        opcode         = OP_LOAD;
    logic [5:0]  row_index      = '0;
    logic [63:0] row_bits       = '0;
    logic [6:0]  start_vertex   = '0;
    logic        out_stall      = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [63:0] reached_mask;
    logic        bad_start;
    int          fail_count;
    int          pending_results;

    bit          sender_gaps = 1'b1;
    bit          sink_stalls = 1'b1;
    bit          hold_now    = 1'b0;
    int          cur_count   = 64;

    graph_reachability_dfs_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .row_index     (row_index),
        .row_bits      (row_bits),
        .start_vertex  (start_vertex),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .reached_mask  (reached_mask),
        .bad_start     (bad_start)
    );

    graph_reachability_dfs_checker u_reach_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .row_index      (row_index),
        .row_bits       (row_bits),
        .start_vertex   (start_vertex),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .reached_mask   (reached_mask),
        .bad_start      (bad_start),
        .fail_count     (fail_count),
        .pending_results(pending_results)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("graph_reachability_dfs_unit verification failed");
        $finish;
    end

    // result side: random stall bursts and one long hold on request
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_now) begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
                hold_now = 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // offer one item and hold it until accepted
    task automatic push_item(input logic op, input logic [5:0] row,
                             input logic [63:0] bits, input logic [6:0] start);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        opcode       <= op;
        row_index    <= row;
        row_bits     <= bits;
        start_vertex <= start;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_load(input logic [5:0] row, input logic [63:0] bits);
        push_item(OP_LOAD, row, bits, 7'($urandom));
    endtask

    task automatic send_search(input logic [6:0] start);
        push_item(OP_SEARCH, 6'($urandom), {$urandom, $urandom}, start);
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results == 0);
        repeat (8) @(posedge clk);
    endtask

    // vertex count write, only while the unit is idle
    task automatic set_count(input int count);
        drain();
        cfg_write_data <= 7'(count);
        cfg_write_en   <= 1'b1;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        cur_count = count;
    endtask

    // vertices in use under the current count, at least one
    function automatic int live_span();
        if (cur_count > MAX_VERTS) return MAX_VERTS;
        if (cur_count < 1) return 1;
        return cur_count;
    endfunction

    // sparse rows mostly, so that searches give varied masks
    function automatic logic [63:0] rand_row(input int span);
        logic [63:0] r;
        r = '0;
        case ($urandom_range(0, 9))
            0:       r = '0;
            1:       r = '1;
            2, 3:    r = {$urandom, $urandom};
            default: begin
                repeat ($urandom_range(1, 3)) r[$urandom_range(0, span - 1)] = 1'b1;
            end
        endcase
        return r;
    endfunction

    // one random item: row load or search, now and then a bad start
    task automatic random_item;
        int span;
        span = live_span();
        if ($urandom_range(0, 9) < 4) begin
            if ($urandom_range(0, 9) < 7)
                send_load(6'($urandom_range(0, span - 1)), rand_row(span));
            else
                send_load(6'($urandom), rand_row(64));
        end
        else if (cur_count > 0 && $urandom_range(0, 9) < 8) begin
            send_search(7'($urandom_range(1, span)));
        end
        else begin
            send_search(7'($urandom_range(0, 127)));
        end
    endtask

    // main sequence
    initial begin
        int n_count;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every row written before any search reads it
        for (int r = 0; r < MAX_VERTS; r++) begin
            send_load(6'(r), rand_row(64));
        end

        // directed: start extremes, bad starts, isolated and full rows
        send_search(7'd1);
        send_search(7'd64);
        send_search(7'd0);
        send_search(7'd65);
        send_search(7'd127);
        send_load(6'd0, '0);
        send_search(7'd1);
        send_load(6'd63, '1);
        send_search(7'd64);
        send_load(6'd10, 64'h8000_0000_0000_0001);
        send_search(7'd11);
        // zero count: every search is a bad start
        set_count(0);
        send_search(7'd1);
        send_search(7'd64);
        // single vertex
        set_count(1);
        send_search(7'd1);
        send_search(7'd2);
        // count above the limit acts as the limit
        set_count(127);
        send_search(7'd64);
        send_search(7'd65);
        send_search(7'd127);
        // edges past the count are not followed
        set_count(2);
        send_load(6'd1, '1);
        send_search(7'd2);

        // random phases under changing vertex counts
        for (int p = 0; p < 10; p++) begin
            case ($urandom_range(0, 7))
                0:       n_count = 1;
                1:       n_count = 64;
                2:       n_count = $urandom_range(65, 127);
                3:       n_count = $urandom_range(2, 8);
                default: n_count = $urandom_range(3, 64);
            endcase
            if (p == 0) n_count = 64;
            if (p == 6) n_count = 0;
            if (p == 9) begin
                sender_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            set_count(n_count);
            if (p == 2) begin
                // long output hold while searches keep coming
                sender_gaps = 1'b0;
                hold_now = 1'b1;
                repeat (40) send_search(7'($urandom_range(1, live_span())));
                sender_gaps = 1'b1;
            end
            repeat (137) random_item();
        end

        drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("graph_reachability_dfs_unit verification clean");
        else
            $display("graph_reachability_dfs_unit verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/grdfs_pkg.sv
rtl/core/grdfs_ram.sv
rtl/core/grdfs_ctrl.sv
rtl/core/grdfs_dpath.sv
rtl/core/graph_reachability_dfs_unit.sv
tb/sv/graph_reachability_dfs_checker.sv
tb/sv/tb_graph_reachability_dfs_unit.sv
